// ===== src/bsfb_pkg.sv =====
`timescale 1ns / 1ps

package bsfb_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = CFG_INDEX_W'(1);

    localparam logic [5:0] HDR_BYTES     = 6'd54;
    localparam logic [5:0] OFF_WIDTH_0   = 6'd18;
    localparam logic [5:0] OFF_WIDTH_1   = 6'd19;
    localparam logic [5:0] OFF_WIDTH_2   = 6'd20;
    localparam logic [5:0] OFF_WIDTH_3   = 6'd21;
    localparam logic [5:0] OFF_HEIGHT_0  = 6'd22;
    localparam logic [5:0] OFF_HEIGHT_1  = 6'd23;
    localparam logic [5:0] OFF_HEIGHT_2  = 6'd24;
    localparam logic [5:0] OFF_HEIGHT_3  = 6'd25;
    localparam logic [5:0] OFF_DEPTH_0   = 6'd28;
    localparam logic [5:0] OFF_DEPTH_1   = 6'd29;

    localparam logic [15:0] DEPTH_ALPHA  = 16'd32;

    localparam int PIXEL_X_W = 10;
    localparam int PIXEL_Y_W = 9;
    localparam int COLOR_W   = 32;
    localparam int ADDR_W    = 19;

    typedef struct packed {
        logic [31:0] color;
        logic [30:0] x_off;
        logic [30:0] y_off;
    } pix_t;

endpackage

// ===== src/bmp_stream_to_framebuffer_top.sv =====
`timescale 1ns / 1ps

// BMP byte stream to framebuffer write stream.
// Input channel (s_): one file byte per transfer; s_file_start marks the first
// byte of a new file and restarts header parsing on that byte.
// Result channel (m_): one framebuffer write per on-screen pixel, with screen
// column, row, color word (B 7:0, G 15:8, R 23:16, A 31:24) and word address.
// Config channel (cfg_): index 0 writes origin_x, index 1 origin_y; other
// indexes are dropped. Write only while no pixel is in flight.
// Throughput: one byte per cycle, sustained, whenever m_ready is high.
// Path: the byte that completes a pixel goes through parse/state update,
// then screen position and clipping, then the address multiply-add into the
// output register, with each step registered.
// Reset: origins return to zero and the block ignores bytes until a file start.
// When the receiver stalls, the output register holds its write and the two
// inner stages keep filling; s_ready drops only once all three are occupied.
module bmp_stream_to_framebuffer_top #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_file_byte,
    input  logic                              s_file_start,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bsfb_pkg::PIXEL_X_W-1:0]    m_pixel_x,
    output logic [bsfb_pkg::PIXEL_Y_W-1:0]    m_pixel_y,
    output logic [bsfb_pkg::COLOR_W-1:0]      m_pixel_color,
    output logic [bsfb_pkg::ADDR_W-1:0]       m_word_address,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsfb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bsfb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bsfb_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);

    // configuration
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;

    // parse state
    logic [5:0]  hdr_off_reg,   hdr_off_next;
    logic [31:0] width_reg,     width_next;
    logic [31:0] height_reg,    height_next;
    logic [15:0] bpp_reg,       bpp_next;
    logic [31:0] col_reg,       col_next;
    logic [31:0] row_reg,       row_next;
    logic [1:0]  bip_reg,       bip_next;
    logic [23:0] partial_reg,   partial_next;
    logic [1:0]  pad_reg,       pad_next;
    logic        done_reg,      done_next;

    // pipeline
    logic        a_valid_reg,   a_valid_next;
    pix_t        a_pix_reg,     a_pix_next;
    logic        b_valid_reg,   b_valid_next;
    logic [XW-1:0] b_x_reg;
    logic [YW-1:0] b_y_reg;
    logic [31:0] b_color_reg;
    logic        m_valid_reg,   m_valid_next;
    logic [XW-1:0] m_x_reg;
    logic [YW-1:0] m_y_reg;
    logic [31:0] m_color_reg;
    logic [ADDR_W-1:0] m_addr_reg;

    logic        out_free, b_free, a_free, accept;
    logic [31:0] aw, ah, col_inc, row_inc;
    logic [1:0]  last_bip;
    logic [23:0] partial_new;
    logic [4:0]  pad_prod;
    logic [1:0]  row_pad;
    logic        pix_fire;
    logic signed [33:0] x_pos, y_pos;
    logic        x_ok, y_ok;
    logic [31:0] addr_full;

    assign out_free = !m_valid_reg || m_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_ready  = a_free;
    assign accept   = s_valid && a_free;
    assign cfg_ready = 1'b1;

    assign aw = width_reg[31]  ? 32'(32'd0 - width_reg)  : width_reg;
    assign ah = height_reg[31] ? 32'(32'd0 - height_reg) : height_reg;
    assign col_inc  = 32'(col_reg + 32'd1);
    assign row_inc  = 32'(row_reg + 32'd1);
    assign last_bip = (bpp_reg == DEPTH_ALPHA) ? 2'd3 : 2'd2;
    assign pad_prod = 5'(aw[4:0] * bpp_reg[4:0]);
    assign row_pad  = 2'(2'd0 - pad_prod[4:3]);

    always_comb begin
        partial_new = partial_reg;
        case (bip_reg)
            2'd0:    partial_new[7:0]   = s_file_byte;
            2'd1:    partial_new[15:8]  = s_file_byte;
            2'd2:    partial_new[23:16] = s_file_byte;
            default: partial_new = partial_reg;
        endcase
    end

    // parse and state update
    always_comb begin
        hdr_off_next = hdr_off_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bpp_next     = bpp_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        bip_next     = bip_reg;
        partial_next = partial_reg;
        pad_next     = pad_reg;
        done_next    = done_reg;
        pix_fire     = 1'b0;
        a_pix_next   = a_pix_reg;

        if (accept) begin
            if (s_file_start) begin
                hdr_off_next = 6'd1;
                width_next   = '0;
                height_next  = '0;
                bpp_next     = '0;
                col_next     = '0;
                row_next     = '0;
                bip_next     = '0;
                partial_next = '0;
                pad_next     = '0;
                done_next    = 1'b0;
            end else if (!done_reg) begin
                if (hdr_off_reg < HDR_BYTES) begin
                    case (hdr_off_reg)
                        OFF_WIDTH_0:  width_next[7:0]   = s_file_byte;
                        OFF_WIDTH_1:  width_next[15:8]  = s_file_byte;
                        OFF_WIDTH_2:  width_next[23:16] = s_file_byte;
                        OFF_WIDTH_3:  width_next[31:24] = s_file_byte;
                        OFF_HEIGHT_0: height_next[7:0]   = s_file_byte;
                        OFF_HEIGHT_1: height_next[15:8]  = s_file_byte;
                        OFF_HEIGHT_2: height_next[23:16] = s_file_byte;
                        OFF_HEIGHT_3: height_next[31:24] = s_file_byte;
                        OFF_DEPTH_0:  bpp_next[7:0]  = s_file_byte;
                        OFF_DEPTH_1:  bpp_next[15:8] = s_file_byte;
                        default:      hdr_off_next = 6'(hdr_off_reg + 6'd1);
                    endcase
                    hdr_off_next = 6'(hdr_off_reg + 6'd1);
                    if (hdr_off_next == HDR_BYTES &&
                        (width_reg == 32'd0 || height_reg == 32'd0)) begin
                        done_next = 1'b1;
                    end
                end else if (pad_reg != 2'd0) begin
                    pad_next = 2'(pad_reg - 2'd1);
                    if (pad_reg == 2'd1) begin
                        row_next = row_inc;
                        if (row_inc >= ah) begin
                            done_next = 1'b1;
                        end
                    end
                end else if (bip_reg < last_bip) begin
                    partial_next = partial_new;
                    bip_next     = 2'(bip_reg + 2'd1);
                end else begin
                    pix_fire     = 1'b1;
                    bip_next     = '0;
                    partial_next = '0;
                    a_pix_next.color = {(last_bip == 2'd3) ? s_file_byte : 8'd0,
                                        partial_new};
                    if (!width_reg[31] && width_reg != 32'd0) begin
                        a_pix_next.x_off = col_reg[30:0];
                    end else begin
                        a_pix_next.x_off = 31'(aw - 32'd1 - col_reg);
                    end
                    if (height_reg[31]) begin
                        a_pix_next.y_off = row_reg[30:0];
                    end else begin
                        a_pix_next.y_off = 31'(ah - 32'd1 - row_reg);
                    end
                    col_next = col_inc;
                    if (col_inc >= aw) begin
                        col_next = '0;
                        pad_next = row_pad;
                        if (row_pad == 2'd0) begin
                            row_next = row_inc;
                            if (row_inc >= ah) begin
                                done_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // screen position and clipping
    assign x_pos = 34'(origin_x_reg) + $signed({3'd0, a_pix_reg.x_off});
    assign y_pos = 34'(origin_y_reg) + $signed({3'd0, a_pix_reg.y_off});
    assign x_ok  = !x_pos[33] && (x_pos < 34'(SCREEN_WIDTH));
    assign y_ok  = !y_pos[33] && (y_pos < 34'(SCREEN_HEIGHT));

    assign addr_full = 32'(32'(SCREEN_WIDTH) * 32'(b_y_reg) + 32'(b_x_reg));

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = pix_fire;
        end else if (b_free) begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (b_free) begin
            b_valid_next = a_valid_reg && x_ok && y_ok;
        end

        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            hdr_off_reg  <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            bpp_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            bip_reg      <= '0;
            partial_reg  <= '0;
            pad_reg      <= '0;
            done_reg     <= 1'b1;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ORIGIN_X: origin_x_reg <= $signed(cfg_data);
                    REG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data);
                    default:      origin_x_reg <= origin_x_reg;
                endcase
            end
            hdr_off_reg  <= hdr_off_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            bpp_reg      <= bpp_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            bip_reg      <= bip_next;
            partial_reg  <= partial_next;
            pad_reg      <= pad_next;
            done_reg     <= done_next;
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= b_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg <= a_pix_next;
        end
        if (b_free) begin
            b_x_reg     <= XW'(x_pos);
            b_y_reg     <= YW'(y_pos);
            b_color_reg <= a_pix_reg.color;
        end
        if (out_free) begin
            m_x_reg     <= b_x_reg;
            m_y_reg     <= b_y_reg;
            m_color_reg <= b_color_reg;
            m_addr_reg  <= addr_full[ADDR_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = PIXEL_X_W'(m_x_reg);
    assign m_pixel_y      = PIXEL_Y_W'(m_y_reg);
    assign m_pixel_color  = m_color_reg;
    assign m_word_address = m_addr_reg;

endmodule

// ===== sim/tb_bmp_stream_to_framebuffer_top.sv =====
`timescale 1ns / 1ps

module tb_bmp_stream_to_framebuffer_top;
    import bsfb_pkg::*;

    localparam int SCREEN_W     = 800;
    localparam int SCREEN_H     = 480;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(2);

    typedef struct packed {
        logic [PIXEL_X_W-1:0] x;
        logic [PIXEL_Y_W-1:0] y;
        logic [COLOR_W-1:0]   color;
        logic [ADDR_W-1:0]    addr;
    } fb_write_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_file_byte;
    logic                   s_file_start;
    logic                   m_valid;
    logic                   m_ready;
    logic [PIXEL_X_W-1:0]   m_pixel_x;
    logic [PIXEL_Y_W-1:0]   m_pixel_y;
    logic [COLOR_W-1:0]     m_pixel_color;
    logic [ADDR_W-1:0]      m_word_address;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // parser shadow state
    logic signed [15:0] org_x = '0;
    logic signed [15:0] org_y = '0;
    logic [5:0]         hdr_pos = '0;
    logic [31:0]        img_w = '0;
    logic [31:0]        img_h = '0;
    logic [15:0]        img_depth = '0;
    logic [31:0]        col_idx = '0;
    logic [31:0]        row_idx = '0;
    logic [1:0]         byte_idx = '0;
    logic [23:0]        color_acc = '0;
    logic [1:0]         pad_left = '0;
    logic               img_idle = 1'b1;

    fb_write_t pending_writes[$];
    fb_write_t got_w;
    fb_write_t want_w;
    int        mismatches = 0;
    bit        src_gaps = 1'b0;
    bit        sink_gaps = 1'b0;

    bmp_stream_to_framebuffer_top #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_file_byte   (s_file_byte),
        .s_file_start  (s_file_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_word_address(m_word_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [1:0] row_pad(input logic [31:0] w, input logic [15:0] d);
        logic [63:0] row_bytes;
        row_bytes = (64'(abs32(w)) * 64'(d)) >> 3;
        return 2'(3'd4 - {1'b0, row_bytes[1:0]});
    endfunction

    function automatic longint file_len(input logic [31:0] w, input logic [31:0] h,
                                        input logic [15:0] d);
        longint psize;
        psize = (d == DEPTH_ALPHA) ? 4 : 3;
        return longint'(abs32(h)) * (longint'(abs32(w)) * psize + longint'(row_pad(w, d)));
    endfunction

    task automatic close_row();
        row_idx++;
        if (row_idx >= abs32(img_h))
            img_idle = 1'b1;
    endtask

    task automatic advance_parser(input logic [7:0] b, input logic st);
        logic [1:0]  last_byte;
        logic [31:0] color;
        logic [31:0] aw;
        logic [31:0] ah;
        longint      px;
        longint      py;
        fb_write_t   w;
        if (st) begin
            hdr_pos   = '0;
            img_w     = '0;
            img_h     = '0;
            img_depth = '0;
            col_idx   = '0;
            row_idx   = '0;
            byte_idx  = '0;
            color_acc = '0;
            pad_left  = '0;
            img_idle  = 1'b0;
        end
        if (img_idle)
            return;

        if (hdr_pos < HDR_BYTES) begin
            if (hdr_pos >= OFF_WIDTH_0 && hdr_pos <= OFF_WIDTH_3)
                img_w[8*(hdr_pos-OFF_WIDTH_0) +: 8] = b;
            else if (hdr_pos >= OFF_HEIGHT_0 && hdr_pos <= OFF_HEIGHT_3)
                img_h[8*(hdr_pos-OFF_HEIGHT_0) +: 8] = b;
            else if (hdr_pos >= OFF_DEPTH_0 && hdr_pos <= OFF_DEPTH_1)
                img_depth[8*(hdr_pos-OFF_DEPTH_0) +: 8] = b;
            hdr_pos++;
            if (hdr_pos == HDR_BYTES && (abs32(img_w) == 0 || abs32(img_h) == 0))
                img_idle = 1'b1;
            return;
        end

        if (pad_left != 0) begin
            pad_left--;
            if (pad_left == 0)
                close_row();
            return;
        end

        last_byte = (img_depth == DEPTH_ALPHA) ? 2'd3 : 2'd2;
        if (byte_idx < 2'd3)
            color_acc[8*byte_idx +: 8] = b;
        if (byte_idx < last_byte) begin
            byte_idx++;
            return;
        end
        color     = {(last_byte == 2'd3) ? b : 8'h00, color_acc};
        byte_idx  = '0;
        color_acc = '0;

        aw = abs32(img_w);
        ah = abs32(img_h);
        if (!img_w[31] && img_w != 0)
            px = longint'(org_x) + longint'(col_idx);
        else
            px = longint'(org_x) + longint'(aw) - 1 - longint'(col_idx);
        if (img_h[31])
            py = longint'(org_y) + longint'(row_idx);
        else
            py = longint'(org_y) + longint'(ah) - 1 - longint'(row_idx);

        if (px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
            w.x     = px[PIXEL_X_W-1:0];
            w.y     = py[PIXEL_Y_W-1:0];
            w.color = color;
            w.addr  = ADDR_W'(longint'(SCREEN_W) * py + px);
            pending_writes.push_back(w);
        end

        col_idx++;
        if (col_idx >= aw) begin
            col_idx  = '0;
            pad_left = row_pad(img_w, img_depth);
            if (pad_left == 0)
                close_row();
        end
    endtask

    // transfers are seen here in one process: config, then input, then result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ORIGIN_X)
                    org_x = cfg_data;
                else if (cfg_index == REG_ORIGIN_Y)
                    org_y = cfg_data;
            end
            if (s_valid && s_ready)
                advance_parser(s_file_byte, s_file_start);
            if (m_valid && m_ready) begin
                got_w = '{m_pixel_x, m_pixel_y, m_pixel_color, m_word_address};
                if (pending_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected write: x=%0d y=%0d color=%h addr=%0d",
                                 got_w.x, got_w.y, got_w.color, got_w.addr);
                end else begin
                    want_w = pending_writes.pop_front();
                    if (got_w.x !== want_w.x || got_w.y !== want_w.y ||
                        got_w.color !== want_w.color || got_w.addr !== want_w.addr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d,%0d %h %0d got %0d,%0d %h %0d",
                                     want_w.x, want_w.y, want_w.color, want_w.addr,
                                     got_w.x, got_w.y, got_w.color, got_w.addr);
                    end
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (sink_gaps && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_file_byte  <= b;
        s_file_start <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // first n bytes of a header, the first one flagged as file start
    task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                               input logic [15:0] d, input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i >= OFF_WIDTH_0 && i <= OFF_WIDTH_3)
                b = w[8*(i-OFF_WIDTH_0) +: 8];
            else if (i >= OFF_HEIGHT_0 && i <= OFF_HEIGHT_3)
                b = h[8*(i-OFF_HEIGHT_0) +: 8];
            else if (i >= OFF_DEPTH_0 && i <= OFF_DEPTH_1)
                b = d[8*(i-OFF_DEPTH_0) +: 8];
            send_byte(b, i == 0);
        end
    endtask

    task automatic send_data(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] d, input int extra);
        send_header(w, h, d, HDR_BYTES);
        send_data(int'(file_len(w, h, d)) + extra);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_origin(input int x, input int y);
        quiesce();
        write_reg(REG_ORIGIN_X, 16'(x));
        write_reg(REG_ORIGIN_Y, 16'(y));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_images();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_data(4);
        set_origin(0, 0);
        send_file(3, 2, 16'd24, 5);
        send_file(2, -2, DEPTH_ALPHA, 0);
        send_file(-3, 2, 16'd24, 0);
        send_file(-2, -3, DEPTH_ALPHA, 2);
    endtask

    task automatic test_odd_headers();
        send_file(0, 5, 16'd24, 6);
        send_file(4, 0, DEPTH_ALPHA, 6);
        send_file(1, 2, 16'd16, 0);
        send_file(2, 1, 16'hFFFF, 0);
        send_file(3, 1, 16'd0, 0);
        send_file(1, 1, 16'd8, 0);
        // huge sizes: a few pixels, then the next file cuts them off
        send_header(32'h8000_0000, 2, 16'd24, HDR_BYTES);
        send_data(30);
        send_header(3, 32'h8000_0000, 16'd24, HDR_BYTES);
        send_data(40);
        send_header(32'h7FFF_FFFF, 32'h7FFF_FFFF, DEPTH_ALPHA, HDR_BYTES);
        send_data(30);
        send_header(32'h7FFF_FFFF, -3, 16'd24, HDR_BYTES);
        send_data(30);
    endtask

    task automatic test_restart();
        send_header(5, 5, 16'd24, 25);
        send_file(2, 2, DEPTH_ALPHA, 0);
        send_header(4, 3, 16'd24, HDR_BYTES);
        send_data(7);
        send_file(1, 3, 16'd24, 0);
    endtask

    task automatic test_origin();
        quiesce();
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_file(2, 2, 16'd24, 0);
        set_origin(-32768, -32768);
        send_file(2, 2, 16'd24, 0);
        set_origin(32767, 32767);
        send_file(2, -2, DEPTH_ALPHA, 0);
        set_origin(SCREEN_W - 2, SCREEN_H - 2);
        send_file(3, 3, DEPTH_ALPHA, 0);
        set_origin(-1, -1);
        send_file(3, -3, 16'd24, 0);
        // origin moves between the first row and the rest
        set_origin(10, 20);
        send_header(3, 3, 16'd24, HDR_BYTES);
        send_data(12);
        set_origin(100, 200);
        send_data(24);
        set_origin(0, 0);
    endtask

    task automatic test_random_files();
        int          sent;
        int          mag_w;
        int          mag_h;
        int          kind;
        int          cut;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] d;
        longint      len;
        sent = 0;
        while (sent < 400) begin
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 7) == 0)
                    set_origin($urandom_range(0, 65535), $urandom_range(0, 65535));
                else
                    set_origin(int'($urandom_range(0, 820)) - 16,
                               int'($urandom_range(0, 500)) - 16);
            end
            mag_w = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
            mag_h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
            w = $urandom_range(0, 1) ? -mag_w : mag_w;
            h = $urandom_range(0, 1) ? -mag_h : mag_h;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: d = 16'd24;
                5, 6, 7:       d = DEPTH_ALPHA;
                8:             d = 16'($urandom_range(0, 65535));
                default:       d = 16'd16;
            endcase
            len  = file_len(w, h, d);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_file(w, h, d, $urandom_range(0, 3));
                sent += HDR_BYTES + int'(len);
            end else if (kind < 9) begin
                cut = $urandom_range(1, HDR_BYTES + int'(len) - 1);
                if (cut < HDR_BYTES) begin
                    send_header(w, h, d, cut);
                end else begin
                    send_header(w, h, d, HDR_BYTES);
                    send_data(cut - HDR_BYTES);
                end
                sent += cut;
            end else begin
                send_file(w, h, d, 0);
                send_data($urandom_range(1, 12));
                sent += HDR_BYTES + int'(len);
            end
        end
    endtask

    task automatic test_full_rate();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        set_origin(5, 5);
        send_file(6, 4, DEPTH_ALPHA, 0);
        send_file(-5, -3, 16'd24, 0);
        send_file(4, 2, 16'd24, 1);
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_file_byte  <= '0;
        s_file_start <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_basic_images();
        test_odd_headers();
        test_restart();
        test_origin();
        test_random_files();
        test_full_rate();

        quiesce();
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bsfb_pkg.sv
src/bmp_stream_to_framebuffer_top.sv
sim/tb_bmp_stream_to_framebuffer_top.sv
